>>> hw/rtl/mpte_pkg.sv
// Shared types and constants for the MessagePack token encoder.
// No dependencies; every other RTL file imports this package.
`default_nettype none

package mpte_pkg;

    // Token kinds carried in the action field
    typedef enum logic [2:0] {
        ACT_NIL    = 3'd0,
        ACT_BOOL   = 3'd1,
        ACT_INT    = 3'd2,
        ACT_DOUBLE = 3'd3,
        ACT_STR    = 3'd4,
        ACT_ARRAY  = 3'd5,
        ACT_MAP    = 3'd6,
        ACT_BYTE   = 3'd7
    } mpte_action_t;

    // Input word: one token
    typedef struct packed {
        mpte_action_t       action;
        logic signed [63:0] value;
    } mpte_in_t;

    // Output word: one encoded byte
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } mpte_out_t;

    // Classified token: header byte, up to eight trailing bytes left-aligned
    typedef struct packed {
        logic [7:0]  head;
        logic [63:0] data;
        logic [3:0]  len;
    } mpte_entry_t;

    // Queue status seen by the back end
    typedef struct packed {
        logic empty;
        logic full;
    } mpte_q_status_t;

    // Header bytes
    localparam logic [7:0] HD_NIL     = 8'hc0;
    localparam logic [7:0] HD_FALSE   = 8'hc2;
    localparam logic [7:0] HD_TRUE    = 8'hc3;
    localparam logic [7:0] HD_FLOAT32 = 8'hca;
    localparam logic [7:0] HD_FLOAT64 = 8'hcb;
    localparam logic [7:0] HD_UINT8   = 8'hcc;
    localparam logic [7:0] HD_UINT16  = 8'hcd;
    localparam logic [7:0] HD_UINT32  = 8'hce;
    localparam logic [7:0] HD_UINT64  = 8'hcf;
    localparam logic [7:0] HD_INT8    = 8'hd0;
    localparam logic [7:0] HD_INT16   = 8'hd1;
    localparam logic [7:0] HD_INT32   = 8'hd2;
    localparam logic [7:0] HD_INT64   = 8'hd3;
    localparam logic [7:0] HD_STR8    = 8'hd9;
    localparam logic [7:0] HD_STR16   = 8'hda;
    localparam logic [7:0] HD_STR32   = 8'hdb;
    localparam logic [7:0] HD_ARR16   = 8'hdc;
    localparam logic [7:0] HD_ARR32   = 8'hdd;
    localparam logic [7:0] HD_MAP16   = 8'hde;
    localparam logic [7:0] HD_MAP32   = 8'hdf;
    localparam logic [7:0] HD_FIXSTR  = 8'ha0;
    localparam logic [7:0] HD_FIXARR  = 8'h90;
    localparam logic [7:0] HD_FIXMAP  = 8'h80;

    // Trailing byte counts
    localparam logic [3:0] LEN_0 = 4'd0;
    localparam logic [3:0] LEN_1 = 4'd1;
    localparam logic [3:0] LEN_2 = 4'd2;
    localparam logic [3:0] LEN_4 = 4'd4;
    localparam logic [3:0] LEN_8 = 4'd8;

endpackage

`default_nettype wire

>>> hw/rtl/mpte_front.sv
// Front end: classifies one token into header byte, trailing bytes and count.
// Depends on mpte_pkg.
`default_nettype none

module mpte_front (
    input  mpte_pkg::mpte_in_t    token,
    output mpte_pkg::mpte_entry_t entry
);
    import mpte_pkg::*;

    logic [63:0] u;
    logic [63:0] raw;
    logic [7:0]  head;
    logic [3:0]  len;
    logic [31:0] len_sat;

    // double fields
    logic        sgn;
    logic [10:0] ex;
    logic [51:0] man;
    logic [52:0] sig;
    logic [10:0] sh_diff;
    logic [5:0]  sh;
    logic [52:0] mask;
    logic [52:0] sig_sh;
    logic [7:0]  ex32;
    logic        f32_ok;
    logic [31:0] fbits;

    assign u       = token.value;
    assign len_sat = (u > 64'h0000_0000_ffff_ffff) ? 32'hffff_ffff : u[31:0];

    // float32 exactness check
    assign sgn     = u[63];
    assign ex      = u[62:52];
    assign man     = u[51:0];
    assign sig     = {1'b1, man};
    assign sh_diff = 11'd926 - ex;
    assign sh      = sh_diff[5:0];
    assign mask    = (53'd1 << sh) - 53'd1;
    assign sig_sh  = sig >> sh;
    assign ex32    = ex[7:0] - 8'd128;

    always_comb
    begin
        f32_ok = 1'b0;
        fbits  = 32'd0;
        if (ex == 11'h7ff)
        begin
            // infinity is exact, every NaN stays double
            f32_ok = (man == 52'd0);
            fbits  = {sgn, 8'hff, 23'd0};
        end
        else if (ex == 11'd0)
        begin
            // signed zero is exact, double subnormals never are
            f32_ok = (man == 52'd0);
            fbits  = {sgn, 31'd0};
        end
        else if (ex >= 11'd897 && ex <= 11'd1150)
        begin
            // normal float32 range
            f32_ok = (man[28:0] == 29'd0);
            fbits  = {sgn, ex32, man[51:29]};
        end
        else if (ex >= 11'd874 && ex <= 11'd896)
        begin
            // float32 subnormal range
            f32_ok = ((sig & mask) == 53'd0);
            fbits  = {sgn, sig_sh[30:0]};
        end
    end

    // pick header and trailing bytes per token kind
    always_comb
    begin
        head = HD_NIL;
        raw  = 64'd0;
        len  = LEN_0;
        case (token.action)
            ACT_NIL:
            begin
                head = HD_NIL;
            end
            ACT_BOOL:
            begin
                head = (u != 64'd0) ? HD_TRUE : HD_FALSE;
            end
            ACT_INT:
            begin
                raw = u;
                if (!u[63])
                begin
                    if (u <= 64'h7f)
                        head = u[7:0];
                    else if (u <= 64'hff)
                        begin head = HD_UINT8;  len = LEN_1; end
                    else if (u <= 64'hffff)
                        begin head = HD_UINT16; len = LEN_2; end
                    else if (u <= 64'hffff_ffff)
                        begin head = HD_UINT32; len = LEN_4; end
                    else
                        begin head = HD_UINT64; len = LEN_8; end
                end
                else
                begin
                    if (u >= 64'hffff_ffff_ffff_ffe0)
                        head = u[7:0];
                    else if (u >= 64'hffff_ffff_ffff_ff80)
                        begin head = HD_INT8;  len = LEN_1; end
                    else if (u >= 64'hffff_ffff_ffff_8000)
                        begin head = HD_INT16; len = LEN_2; end
                    else if (u >= 64'hffff_ffff_8000_0000)
                        begin head = HD_INT32; len = LEN_4; end
                    else
                        begin head = HD_INT64; len = LEN_8; end
                end
            end
            ACT_DOUBLE:
            begin
                if (f32_ok)
                begin
                    head = HD_FLOAT32;
                    raw  = {32'd0, fbits};
                    len  = LEN_4;
                end
                else
                begin
                    head = HD_FLOAT64;
                    raw  = u;
                    len  = LEN_8;
                end
            end
            ACT_STR:
            begin
                if (u < 64'd32)
                    head = HD_FIXSTR | u[7:0];
                else if (u <= 64'hff)
                    begin head = HD_STR8;  raw = u; len = LEN_1; end
                else if (u <= 64'hffff)
                    begin head = HD_STR16; raw = u; len = LEN_2; end
                else
                    begin head = HD_STR32; raw = {32'd0, len_sat}; len = LEN_4; end
            end
            ACT_ARRAY, ACT_MAP:
            begin
                if (u <= 64'd15)
                    head = ((token.action == ACT_ARRAY) ? HD_FIXARR : HD_FIXMAP) | u[7:0];
                else if (u <= 64'hffff)
                begin
                    head = (token.action == ACT_ARRAY) ? HD_ARR16 : HD_MAP16;
                    raw  = u;
                    len  = LEN_2;
                end
                else
                begin
                    head = (token.action == ACT_ARRAY) ? HD_ARR32 : HD_MAP32;
                    raw  = {32'd0, len_sat};
                    len  = LEN_4;
                end
            end
            ACT_BYTE:
            begin
                head = u[7:0];
            end
            default:
            begin
                head = HD_NIL;
            end
        endcase
    end

    // left-align trailing bytes so the back end shifts out the top byte
    always_comb
    begin
        entry.head = head;
        entry.len  = len;
        case (len)
            LEN_1:   entry.data = {raw[7:0], 56'd0};
            LEN_2:   entry.data = {raw[15:0], 48'd0};
            LEN_4:   entry.data = {raw[31:0], 32'd0};
            LEN_8:   entry.data = raw;
            default: entry.data = 64'd0;
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/mpte_queue.sv
// Short queue of classified tokens between front and back end.
// Depends on mpte_pkg.
`default_nettype none

module mpte_queue #(
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  mpte_pkg::mpte_entry_t    wr_entry,
    input  logic                     pop,
    output mpte_pkg::mpte_entry_t    rd_entry,
    output mpte_pkg::mpte_q_status_t status
);
    import mpte_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mpte_entry_t      mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign rd_entry     = mem[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_entry;
    end

endmodule

`default_nettype wire

>>> hw/rtl/mpte_back.sv
// Back end: serialises one queued token into bytes, one word per cycle.
// Depends on mpte_pkg.
`default_nettype none

module mpte_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  mpte_pkg::mpte_entry_t    rd_entry,
    input  mpte_pkg::mpte_q_status_t status,
    output logic                     pop,
    output logic                     strobe,
    output mpte_pkg::mpte_out_t      result
);
    import mpte_pkg::*;

    logic [3:0]  cnt_reg,    cnt_next;
    logic [63:0] shift_reg,  shift_next;
    logic        strobe_reg, strobe_next;
    mpte_out_t   out_reg,    out_next;

    // emit remaining trailing bytes, else start the next token
    always_comb
    begin
        pop         = 1'b0;
        cnt_next    = cnt_reg;
        shift_next  = shift_reg;
        strobe_next = 1'b0;
        out_next    = out_reg;
        if (cnt_reg != 4'd0)
        begin
            strobe_next       = 1'b1;
            out_next.out_byte = shift_reg[63:56];
            out_next.last     = (cnt_reg == 4'd1);
            shift_next        = {shift_reg[55:0], 8'd0};
            cnt_next          = cnt_reg - 4'd1;
        end
        else if (!status.empty)
        begin
            pop               = 1'b1;
            strobe_next       = 1'b1;
            out_next.out_byte = rd_entry.head;
            out_next.last     = (rd_entry.len == LEN_0);
            shift_next        = rd_entry.data;
            cnt_next          = rd_entry.len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= 4'd0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            strobe_reg <= strobe_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        out_reg   <= out_next;
    end

    assign strobe = strobe_reg;
    assign result = out_reg;

endmodule

`default_nettype wire

>>> hw/rtl/messagepack_token_encoder.sv
// Top level of the MessagePack token encoder.
// Depends on mpte_pkg, mpte_front, mpte_queue and mpte_back.
//
// Usage:
//   Input channel: a token word (action, value) is taken at a rising edge
//   where start is high and busy is low. busy is high only while the token
//   queue is full.
//   Output channel: each encoded byte appears on result for one cycle with
//   strobe high; result.last marks the final byte of a token. Bytes of one
//   token come in consecutive cycles, tokens in order of acceptance.
//   With the block empty, a token is first written into the queue, then its
//   header byte is loaded into the back end's output register.
//   Throughput: the back end emits one byte per cycle, and a token is 1 to
//   9 bytes long (nine for 64-bit integers and float64 doubles, five for
//   float32). Tokens are taken every cycle until the QUEUE_DEPTH-entry
//   queue fills; then a new token is taken only once the back end has
//   popped an entry from the queue.
//   Reset: clears the queue and the serialiser; no bytes are pending after.
//   The receiver cannot stall; bytes are produced unconditionally.
`default_nettype none

module messagepack_token_encoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  mpte_pkg::mpte_in_t  token,
    output logic                strobe,
    output mpte_pkg::mpte_out_t result
);
    import mpte_pkg::*;

    mpte_entry_t    wr_entry;
    mpte_entry_t    rd_entry;
    mpte_q_status_t status;
    logic           push;
    logic           pop;

    assign busy = status.full;
    assign push = start && !status.full;

    // classify
    mpte_front u_front (
        .token (token),
        .entry (wr_entry)
    );

    // decoupling queue
    mpte_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_entry (wr_entry),
        .pop      (pop),
        .rd_entry (rd_entry),
        .status   (status)
    );

    // serialise
    mpte_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_entry (rd_entry),
        .status   (status),
        .pop      (pop),
        .strobe   (strobe),
        .result   (result)
    );

endmodule

`default_nettype wire

>>> hw/rtl/mpte_checker.sv
// Port-level checks for the MessagePack token encoder, bound to the top level.
// Depends on mpte_pkg.
`default_nettype none

module mpte_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input mpte_pkg::mpte_in_t  token,
    input logic                strobe,
    input mpte_pkg::mpte_out_t result
);
    import mpte_pkg::*;

    // nothing pending or shown while reset is held
    assert property (@(posedge clk) !rst_n |-> (!strobe && !busy))
        else $error("strobe or busy high during reset");

    // queue only fills after a token was taken
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && !busy))
        else $error("busy rose without an accepted token");

    // bytes of one token are contiguous
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !result.last) |=> strobe)
        else $error("gap inside a token's bytes");

    // a byte word never comes out of an empty block straight after reset
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !strobe)
        else $error("strobe straight after reset");

endmodule

bind messagepack_token_encoder mpte_checker u_chk (.*);

`default_nettype wire
